>>> rtl/baro_temp_pressure_compensation_top_defines.svh
// assertion helpers shared by the checker
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication on clk, quiet in reset
`define BTPC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("btpc check failed");

// next-cycle implication on clk, quiet in reset
`define BTPC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("btpc check failed");

`endif

>>> rtl/btpc_pkg.sv
package btpc_pkg;

    typedef struct packed {
        logic        cmd;
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } item_t;

    typedef struct packed {
        logic [47:0] press_c;
        logic [47:0] press_b;
        logic [47:0] press_a;
        logic [47:0] temp;
    } calib_t;

    localparam logic [1:0] REG_CALIB_TEMP    = 2'd0;
    localparam logic [1:0] REG_CALIB_PRESS_A = 2'd1;
    localparam logic [1:0] REG_CALIB_PRESS_B = 2'd2;
    localparam logic [1:0] REG_CALIB_PRESS_C = 2'd3;

    localparam logic [31:0] T_ROUND  = 32'd128;
    localparam logic [63:0] P_OFFSET = 64'd128000;
    localparam logic [63:0] P_BASE   = 64'd1048576;
    localparam logic [63:0] P_SCALE  = 64'd3125;
    localparam logic [63:0] P_ONE47  = 64'h0000_8000_0000_0000;

endpackage

>>> rtl/baro_temp_pressure_compensation_top.sv
// throughput: one beat per cycle, set by the fully pipelined datapath and the
//   64-stage radix-2 divider; output stalls freeze the whole back pipeline
// reset: rst_n asynchronous active low, clears queue pointers, valid flags and
//   the four calibration registers
// calibration registers sit at byte addresses 0, 8, 16 and 24 on the apb port
module baro_temp_pressure_compensation_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temp [19:0], raw_press [39:20]
    input  logic [0:0]  s_axis_tuser,   // command [0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // temperature [31:0], pressure [55:32]
    output logic [0:0]  m_axis_tuser,   // pressure_valid [0]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    btpc_pkg::calib_t calib_reg;
    btpc_pkg::item_t  item;
    logic             item_valid;
    logic             item_ready;
    logic             cfg_wr;
    logic [47:0]      rd_word;

    // register write happens on the access phase
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                btpc_pkg::REG_CALIB_TEMP:    calib_reg.temp    <= pwdata[47:0];
                btpc_pkg::REG_CALIB_PRESS_A: calib_reg.press_a <= pwdata[47:0];
                btpc_pkg::REG_CALIB_PRESS_B: calib_reg.press_b <= pwdata[47:0];
                btpc_pkg::REG_CALIB_PRESS_C: calib_reg.press_c <= pwdata[47:0];
                default:                     calib_reg         <= calib_reg;
            endcase
        end
    end

    // read-back mux, upper bits read as zero
    always_comb
    begin
        case (paddr[4:3])
            btpc_pkg::REG_CALIB_TEMP:    rd_word = calib_reg.temp;
            btpc_pkg::REG_CALIB_PRESS_A: rd_word = calib_reg.press_a;
            btpc_pkg::REG_CALIB_PRESS_B: rd_word = calib_reg.press_b;
            btpc_pkg::REG_CALIB_PRESS_C: rd_word = calib_reg.press_c;
            default:                     rd_word = '0;
        endcase
    end

    assign prdata = {16'd0, rd_word};

    // front end: unpacks beats into a short queue so input is still taken
    // while the result side is stalled, until the queue is full
    btpc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    // back end: temperature path, 64-bit pressure path, divider and
    // output register
    btpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .calib         (calib_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/btpc_front.sv
module btpc_front #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,  // raw_temp, raw_press
    input  logic [0:0]          s_axis_tuser,  // command
    output logic                item_valid,
    input  logic                item_ready,
    output btpc_pkg::item_t     item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    btpc_pkg::item_t q_reg [DEPTH];
    btpc_pkg::item_t in_item;
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    // split the beat into its fields
    assign in_item.cmd       = s_axis_tuser[0];
    assign in_item.raw_temp  = s_axis_tdata[19:0];
    assign in_item.raw_press = s_axis_tdata[39:20];

    assign s_axis_tready = (count_reg != CW'(DEPTH));
    assign item_valid    = (count_reg != '0);
    assign item          = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/btpc_mul64.sv
module btpc_mul64 #(
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [LANES-1:0][63:0] a,
    input  logic [LANES-1:0][63:0] b,
    input  logic [SW-1:0]          side_in,
    output logic                   out_vld,
    output logic [LANES-1:0][63:0] p,
    output logic [SW-1:0]          side_out
);

    // low 64 bits of a*b from three 32x32 partial products
    logic [LANES-1:0][63:0] ll_reg;
    logic [LANES-1:0][31:0] lh_reg;
    logic [LANES-1:0][31:0] hl_reg;
    logic [LANES-1:0][63:0] p_reg;
    logic [SW-1:0]          side1_reg, side2_reg;
    logic                   vld1_reg, vld2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ll_reg[i] <= a[i][31:0] * b[i][31:0];
                lh_reg[i] <= a[i][31:0] * b[i][63:32];
                hl_reg[i] <= a[i][63:32] * b[i][31:0];
                p_reg[i]  <= ll_reg[i] + {lh_reg[i] + hl_reg[i], 32'd0};
            end
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign p        = p_reg;
    assign side_out = side2_reg;
    assign out_vld  = vld2_reg;

endmodule

>>> rtl/btpc_div.sv
module btpc_div #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [63:0]   num,
    input  logic [63:0]   den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [63:0]   quo,
    output logic [SW-1:0] side_out
);

    // restoring divider, one quotient bit per stage
    localparam int N = 64;

    logic [63:0]   rem_reg  [N+1];
    logic [63:0]   dvd_reg  [N+1];
    logic [63:0]   dsr_reg  [N+1];
    logic          neg_reg  [N+1];
    logic [SW-1:0] side_reg [N+1];
    logic          vld_reg  [N+1];
    logic [63:0]   quo_reg;
    logic [SW-1:0] side_out_reg;
    logic          out_vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= '0;
            dvd_reg[0]   <= num[63] ? (64'd0 - num) : num;
            dsr_reg[0]   <= den[63] ? (64'd0 - den) : den;
            neg_reg[0]   <= num[63] ^ den[63];
            side_reg[0]  <= side_in;
            quo_reg      <= neg_reg[N] ? (64'd0 - dvd_reg[N]) : dvd_reg[N];
            side_out_reg <= side_reg[N];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0]  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0]  <= in_vld;
            out_vld_reg <= vld_reg[N];
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [64:0] trial;
        logic        take;

        assign trial = {rem_reg[i], dvd_reg[i][63]} - {1'b0, dsr_reg[i]};
        assign take  = ~trial[64];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= take ? trial[63:0] : {rem_reg[i][62:0], dvd_reg[i][63]};
                dvd_reg[i+1]  <= {dvd_reg[i][62:0], take};
                dsr_reg[i+1]  <= dsr_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    assign quo      = quo_reg;
    assign side_out = side_out_reg;
    assign out_vld  = out_vld_reg;

endmodule

>>> rtl/btpc_back.sv
module btpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  btpc_pkg::item_t   item,
    input  btpc_pkg::calib_t  calib,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // temperature, pressure
    output logic [0:0]        m_axis_tuser   // pressure_valid
);

    function automatic logic [63:0] sx16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
        return $unsigned($signed(x) >>> s);
    endfunction

    logic adv;

    // calibration words
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, calib.temp[15:0]};
    assign t2 = {{16{calib.temp[31]}}, calib.temp[31:16]};
    assign t3 = {{16{calib.temp[47]}}, calib.temp[47:32]};
    assign p1 = {48'd0, calib.press_a[15:0]};
    assign p2 = sx16(calib.press_a[31:16]);
    assign p3 = sx16(calib.press_a[47:32]);
    assign p4 = sx16(calib.press_b[15:0]);
    assign p5 = sx16(calib.press_b[31:16]);
    assign p6 = sx16(calib.press_b[47:32]);
    assign p7 = sx16(calib.press_c[15:0]);
    assign p8 = sx16(calib.press_c[31:16]);
    assign p9 = sx16(calib.press_c[47:32]);

    // temperature stages
    logic [31:0] x1_reg, d_reg, pa_reg, dd_reg, a_reg, pb_reg, fine_reg, temp5_reg;
    logic [63:0] v1_reg;
    logic [19:0] adcp1_reg, adcp2_reg, adcp3_reg, adcp4_reg, adcp5_reg;
    logic [4:0]  cmd_reg;
    logic [4:0]  vld_reg;
    logic [31:0] fine5;

    assign adv        = !m_axis_tvalid || m_axis_tready;
    assign item_ready = adv;
    assign fine5      = {fine_reg[29:0], 2'b00} + fine_reg + btpc_pkg::T_ROUND;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= {15'd0, item.raw_temp[19:3]} - {t1[30:0], 1'b0};
            d_reg     <= {16'd0, item.raw_temp[19:4]} - t1;
            adcp1_reg <= item.raw_press;
            pa_reg    <= x1_reg * t2;
            dd_reg    <= d_reg * d_reg;
            adcp2_reg <= adcp1_reg;
            a_reg     <= asr32(pa_reg, 5'd11);
            pb_reg    <= asr32(dd_reg, 5'd12) * t3;
            adcp3_reg <= adcp2_reg;
            fine_reg  <= a_reg + asr32(pb_reg, 5'd14);
            adcp4_reg <= adcp3_reg;
            temp5_reg <= asr32(fine5, 5'd8);
            v1_reg    <= {{32{fine_reg[31]}}, fine_reg} - btpc_pkg::P_OFFSET;
            adcp5_reg <= adcp4_reg;
            cmd_reg   <= {cmd_reg[3:0], item.cmd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], item_valid};
        end
    end

    // v1*v1, v1*p5, v1*p2
    logic [2:0][63:0] pa_a, pa_b, pa_p;
    logic [52:0]      sa_out;
    logic             va_out;

    assign pa_a = {v1_reg, v1_reg, v1_reg};
    assign pa_b = {p2, p5, v1_reg};

    btpc_mul64 #(.LANES(3), .SW(53)) u_mul_a (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld_reg[4]),
        .a(pa_a), .b(pa_b), .side_in({temp5_reg, cmd_reg[4], adcp5_reg}),
        .out_vld(va_out), .p(pa_p), .side_out(sa_out)
    );

    logic [63:0] vv8_reg, v2b8_reg, c8_reg;
    logic [52:0] s8_reg;
    logic        vld8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vv8_reg  <= pa_p[0];
            v2b8_reg <= {pa_p[1][46:0], 17'd0} + {p4[28:0], 35'd0};
            c8_reg   <= {pa_p[2][51:0], 12'd0};
            s8_reg   <= sa_out;
        end
    end

    // v1^2*p6, v1^2*p3
    logic [1:0][63:0] pb_a, pb_b, pb_p;
    logic [180:0]     sb_out;
    logic             vb_out;

    assign pb_a = {vv8_reg, vv8_reg};
    assign pb_b = {p3, p6};

    btpc_mul64 #(.LANES(2), .SW(181)) u_mul_b (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld8_reg),
        .a(pb_a), .b(pb_b), .side_in({s8_reg, v2b8_reg, c8_reg}),
        .out_vld(vb_out), .p(pb_p), .side_out(sb_out)
    );

    logic [63:0] v2_11_reg, s11_reg, nm12_reg, s12_reg;
    logic [52:0] s11_side_reg;
    logic [32:0] s12_side_reg;
    logic        vld11_reg, vld12_reg;
    logic [63:0] pbase;

    assign pbase = btpc_pkg::P_BASE - {44'd0, s11_side_reg[19:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v2_11_reg    <= pb_p[0] + sb_out[127:64];
            s11_reg      <= btpc_pkg::P_ONE47 + asr64(pb_p[1], 6'd8) + sb_out[63:0];
            s11_side_reg <= sb_out[180:128];
            nm12_reg     <= {pbase[32:0], 31'd0} - v2_11_reg;
            s12_reg      <= s11_reg;
            s12_side_reg <= s11_side_reg[52:20];
        end
    end

    // (2^47 + (v1^2*p3 >> 8) + (v1*p2 << 12))*p1, numerator*3125
    logic [1:0][63:0] pc_a, pc_b, pc_p;
    logic [32:0]      sc_out;
    logic             vc_out;

    assign pc_a = {nm12_reg, s12_reg};
    assign pc_b = {btpc_pkg::P_SCALE, p1};

    btpc_mul64 #(.LANES(2), .SW(33)) u_mul_c (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld12_reg),
        .a(pc_a), .b(pc_b), .side_in(s12_side_reg),
        .out_vld(vc_out), .p(pc_p), .side_out(sc_out)
    );

    logic [63:0] vd15_reg, num15_reg;
    logic [31:0] temp15_reg;
    logic        cmd15_reg, vld15_reg;
    logic        ok15;

    assign ok15 = cmd15_reg && (vd15_reg != 64'd0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vd15_reg   <= asr64(pc_p[0], 6'd33);
            num15_reg  <= pc_p[1];
            temp15_reg <= sc_out[32:1];
            cmd15_reg  <= sc_out[0];
        end
    end

    logic [63:0] quo;
    logic [32:0] sq_out;
    logic        vq_out;

    btpc_div #(.SW(33)) u_div (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld15_reg),
        .num(num15_reg), .den(vd15_reg), .side_in({temp15_reg, ok15}),
        .out_vld(vq_out), .quo(quo), .side_out(sq_out)
    );

    // (q>>13)*p9 and q*p8
    logic [1:0][63:0] pd_a, pd_b, pd_p;
    logic [96:0]      sd_out;
    logic             vd_out;

    assign pd_a = {quo, asr64(quo, 6'd13)};
    assign pd_b = {p8, p9};

    btpc_mul64 #(.LANES(2), .SW(97)) u_mul_d (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vq_out),
        .a(pd_a), .b(pd_b), .side_in({sq_out, quo}),
        .out_vld(vd_out), .p(pd_p), .side_out(sd_out)
    );

    // ((q>>13)*p9)*(q>>13)
    logic [0:0][63:0] pe_a, pe_b, pe_p;
    logic [160:0]     se_out;
    logic             ve_out;

    assign pe_a = pd_p[0];
    assign pe_b = asr64(sd_out[63:0], 6'd13);

    btpc_mul64 #(.LANES(1), .SW(161)) u_mul_e (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vd_out),
        .a(pe_a), .b(pe_b), .side_in({sd_out, asr64(pd_p[1], 6'd19)}),
        .out_vld(ve_out), .p(pe_p), .side_out(se_out)
    );

    logic [63:0] r_reg;
    logic [31:0] tempf_reg;
    logic        okf_reg, vldf_reg;
    logic [63:0] pfin;
    logic [55:0] out_data_reg;
    logic        out_user_reg, out_vld_reg;

    assign pfin = asr64(r_reg, 6'd8) + {p7[59:0], 4'd0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg     <= se_out[127:64] + asr64(pe_p[0], 6'd25) + se_out[63:0];
            tempf_reg <= se_out[160:129];
            okf_reg   <= se_out[128];
            if (vldf_reg)
            begin
                out_data_reg <= {okf_reg ? pfin[31:8] : 24'd0, tempf_reg};
                out_user_reg <= okf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld8_reg    <= 1'b0;
            vld11_reg   <= 1'b0;
            vld12_reg   <= 1'b0;
            vld15_reg   <= 1'b0;
            vldf_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld8_reg    <= va_out;
            vld11_reg   <= vb_out;
            vld12_reg   <= vld11_reg;
            vld15_reg   <= vc_out;
            vldf_reg    <= ve_out;
            out_vld_reg <= vldf_reg;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

endmodule

>>> rtl/btpc_chk.sv
`include "baro_temp_pressure_compensation_top_defines.svh"

module btpc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready
);

    logic out_stall;
    logic cfg_wr;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // a held result beat stays valid and keeps its payload
    `BTPC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)
    `BTPC_ASSERT_NEXT(a_out_data, out_stall, $stable({m_axis_tdata, m_axis_tuser}))
    // pressure reads zero unless flagged valid
    `BTPC_ASSERT_NOW(a_press_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[55:32] == 24'd0)
    // a write is reflected on read-back of the same address next cycle
    `BTPC_ASSERT_NEXT(a_cfg_rb, cfg_wr, (paddr != $past(paddr)) || (prdata[47:0] == $past(pwdata[47:0])))

endmodule

bind baro_temp_pressure_compensation_top btpc_chk u_chk (.*);
